// ===== hw/rtl/chrp_pkg.sv =====
// Shared types and constants for the consistent-hash ring placement block.
// Depends on nothing; every other file of the block imports it.
package chrp_pkg;

  localparam int NODES          = 16;
  localparam int NODE_W         = 4;
  localparam int NP_W           = 5;
  localparam int POS_W          = 64;
  localparam int TYPE_W         = 2;
  localparam int RANK_W         = 3;
  localparam int STAT_W         = 3;
  localparam int RC_W           = 4;
  localparam int RESET_REPLICAS = 4;

  // Request type codes as they arrive on the input word.
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd2;

  // Status codes of a result word.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [NODE_W-1:0] node;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_FINISH,
    B_EMIT
  } bstate_t;

endpackage

// ===== hw/rtl/chrp_if.sv =====
// Channel interfaces of the ring placement block: request, result and configuration.
// Depends on chrp_pkg for the field widths.
interface chrp_req_if;
  import chrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [POS_W-1:0]  ring_position;
  logic [NODE_W-1:0] node_number;
  modport source (output valid, req_type, ring_position, node_number, input ready);
  modport sink (input valid, req_type, ring_position, node_number, output ready);
endinterface

interface chrp_res_if;
  import chrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] owner_node;
  logic [RANK_W-1:0] replica_rank;
  logic [STAT_W-1:0] status;
  logic              last;
  modport source (output valid, owner_node, replica_rank, status, last, input ready);
  modport sink (input valid, owner_node, replica_rank, status, last, output ready);
endinterface

interface chrp_cfg_if;
  import chrp_pkg::*;
  logic            valid;
  logic            ready;
  logic [RC_W-1:0] replica_count;
  modport source (output valid, replica_count, input ready);
  modport sink (input valid, replica_count, output ready);
endinterface

// ===== hw/rtl/consistent_hash_ring_placement_top.sv =====
// Top level of the consistent-hash ring placement block: replica count register,
// front end and back end. Depends on chrp_pkg, chrp_if, chrp_front and chrp_back.
//
//  channel | dir | words carried                                  | accepted when
//  in_ch   | in  | req_type, ring_position, node_number           | valid && ready
//  out_ch  | out | owner_node, replica_rank, status, last         | valid && ready
//  cfg_ch  | in  | replica_count                                  | valid && ready
//
// An insert or remove makes one full pass of the table through its single read
// port, then passes through the drain, finish and result states.
// A lookup makes one such pass per ring step and sends each owner from the result state;
// the ring walk repeats the table pass once for each virtual node it visits.
// An empty-ring lookup and a remove of an absent node go straight to the result state.
// Reset (rst_n low, synchronous) clears all entry flags, node counts and queues and
// sets the replica count to four. A stalled result waits in the output register while
// the front end keeps queueing up to two request words.
module consistent_hash_ring_placement_top #(
  parameter int TABLE_DEPTH  = 64,
  parameter int MAX_REPLICAS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  chrp_req_if.sink   in_ch,
  chrp_res_if.source out_ch,
  chrp_cfg_if.sink   cfg_ch
);
  import chrp_pkg::*;

  logic [RC_W-1:0] rc_r;
  cmd_t            q_cmd;
  logic            q_valid;
  logic            q_pop;

  // The replica count register takes a write on any cycle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= RC_W'(RESET_REPLICAS);
    end else if (cfg_ch.valid) begin
      rc_r <= cfg_ch.replica_count;
    end
  end

  // The front end classifies request words and holds them in a two-deep queue.
  chrp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // The back end owns the ring table and runs each command to completion.
  chrp_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_cmd         (q_cmd),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .replica_count (rc_r),
    .out_ch        (out_ch)
  );

endmodule

// ===== hw/rtl/chrp_front.sv =====
// Front end: accepts request words, classifies them and queues commands.
// Depends on chrp_pkg and chrp_if.
module chrp_front (
  input  logic             clk,
  input  logic             rst_n,
  chrp_req_if.sink         in_ch,
  output chrp_pkg::cmd_t   q_cmd,
  output logic             q_valid,
  input  logic             q_pop
);
  import chrp_pkg::*;

  localparam int QD = 2;

  cmd_t       q_r [QD];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       keep;
  op_t        op;
  logic       push;

  // Request type 3 carries no work and is dropped here.
  always_comb begin
    keep = 1'b1;
    op   = OP_INSERT;
    unique case (in_ch.req_type)
      REQ_INSERT: op = OP_INSERT;
      REQ_REMOVE: op = OP_REMOVE;
      REQ_LOOKUP: op = OP_LOOKUP;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'(QD));
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op, pos: in_ch.ring_position, node: in_ch.node_number};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/chrp_back.sv =====
// Back end: ring table, scan engine and result register of the placement block.
// Depends on chrp_pkg and chrp_if.
module chrp_back #(
  parameter int TABLE_DEPTH  = 64,
  parameter int MAX_REPLICAS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chrp_pkg::cmd_t             q_cmd,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [chrp_pkg::RC_W-1:0]  replica_count,
  chrp_res_if.source                 out_ch
);
  import chrp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  // Ring table memories and per-entry valid flags.
  logic [POS_W-1:0]       pos_mem [TABLE_DEPTH];
  logic [NODE_W-1:0]      own_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CW-1:0]          cnt_r [NODES];
  logic [NP_W-1:0]        np_r;

  bstate_t           state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic [POS_W-1:0]  rd_pos_r;
  logic [NODE_W-1:0] rd_own_r;

  op_t               op_r, op_nxt;
  logic [POS_W-1:0]  key_r, key_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NP_W-1:0]   want_r, want_nxt;
  logic [NP_W-1:0]   n_r, n_nxt;
  logic [NODES-1:0]  seen_r, seen_nxt;

  logic              dup_r, dup_nxt;
  logic              free_ok_r, free_ok_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;
  logic              best_ok_r, best_ok_nxt;
  logic [POS_W-1:0]  best_pos_r, best_pos_nxt;
  logic [NODE_W-1:0] best_own_r, best_own_nxt;
  logic              low_ok_r, low_ok_nxt;
  logic [POS_W-1:0]  low_pos_r, low_pos_nxt;
  logic [NODE_W-1:0] low_own_r, low_own_nxt;

  logic [NODE_W-1:0] res_own_r, res_own_nxt;
  logic [RANK_W-1:0] res_rank_r, res_rank_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              res_last_r, res_last_nxt;
  logic              cont_r, cont_nxt;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_own_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [STAT_W-1:0] out_stat_r;
  logic              out_last_r;

  logic              out_free;
  logic              ent_valid;
  logic [POS_W-1:0]  cur_pos;
  logic [NODE_W-1:0] cur_own;
  logic              own_new;
  logic [RC_W-1:0]   rc_min1;
  logic [RC_W-1:0]   rc_sat;
  logic [NP_W-1:0]   want_calc;
  logic              scan_start;
  logic              ins_commit;
  logic              rem_commit;
  logic              load_out;
  logic              rem_clear;
  logic              last_calc;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign ent_valid = valid_r[rd_idx_r];
  assign cur_pos   = best_ok_r ? best_pos_r : low_pos_r;
  assign cur_own   = best_ok_r ? best_own_r : low_own_r;
  assign own_new   = !seen_r[cur_own];
  assign last_calc = ((n_r + NP_W'(1)) == want_r);

  always_comb begin
    rc_min1   = (replica_count == '0) ? RC_W'(1) : replica_count;
    rc_sat    = (int'(rc_min1) > MAX_REPLICAS) ? RC_W'(MAX_REPLICAS) : rc_min1;
    want_calc = (NP_W'(rc_sat) > np_r) ? np_r : NP_W'(rc_sat);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_LOOKUP && np_r == '0) begin
            state_nxt = B_EMIT;
          end else if (q_cmd.op == OP_REMOVE && cnt_r[q_cmd.node] == '0) begin
            state_nxt = B_EMIT;
          end else begin
            state_nxt = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: state_nxt = B_FINISH;
      B_FINISH: begin
        if (op_r == OP_LOOKUP && !own_new) begin
          state_nxt = B_SCAN;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_nxt = cont_r ? B_SCAN : B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control and datapath outputs.
  always_comb begin
    q_pop      = (state_r == B_IDLE) && q_valid;
    scan_start = (state_nxt == B_SCAN) && (state_r != B_SCAN);
    ins_commit = (state_r == B_FINISH) && (op_r == OP_INSERT) && !dup_r && free_ok_r;
    rem_commit = (state_r == B_FINISH) && (op_r == OP_REMOVE);
    load_out   = (state_r == B_EMIT) && out_free;
    rem_clear  = rd_vld_r && (op_r == OP_REMOVE) && ent_valid && (rd_own_r == node_r);

    op_nxt       = op_r;
    key_nxt      = key_r;
    node_nxt     = node_r;
    want_nxt     = want_r;
    n_nxt        = n_r;
    seen_nxt     = seen_r;
    res_own_nxt  = res_own_r;
    res_rank_nxt = res_rank_r;
    res_stat_nxt = res_stat_r;
    res_last_nxt = res_last_r;
    cont_nxt     = cont_r;

    if (q_pop) begin
      op_nxt       = q_cmd.op;
      key_nxt      = q_cmd.pos;
      node_nxt     = q_cmd.node;
      want_nxt     = want_calc;
      n_nxt        = '0;
      seen_nxt     = '0;
      res_own_nxt  = (q_cmd.op == OP_LOOKUP) ? '0 : q_cmd.node;
      res_rank_nxt = '0;
      res_stat_nxt = (q_cmd.op == OP_LOOKUP) ? ST_EMPTY : ST_NOTFOUND;
      res_last_nxt = 1'b1;
      cont_nxt     = 1'b0;
    end else if (state_r == B_FINISH) begin
      if (op_r == OP_LOOKUP) begin
        key_nxt = cur_pos;
        if (own_new) begin
          seen_nxt[cur_own] = 1'b1;
          n_nxt             = n_r + NP_W'(1);
          res_own_nxt       = cur_own;
          res_rank_nxt      = n_r[RANK_W-1:0];
          res_stat_nxt      = ST_OK;
          res_last_nxt      = last_calc;
          cont_nxt          = !last_calc;
        end
      end else begin
        res_own_nxt  = node_r;
        res_rank_nxt = '0;
        res_last_nxt = 1'b1;
        cont_nxt     = 1'b0;
        if (op_r == OP_REMOVE) begin
          res_stat_nxt = ST_OK;
        end else if (dup_r) begin
          res_stat_nxt = ST_DUP;
        end else if (!free_ok_r) begin
          res_stat_nxt = ST_FULL;
        end else begin
          res_stat_nxt = ST_OK;
        end
      end
    end

    addr_nxt = addr_r;
    if (scan_start) begin
      addr_nxt = '0;
    end else if (state_r == B_SCAN) begin
      addr_nxt = addr_r + AW'(1);
    end

    dup_nxt      = dup_r;
    free_ok_nxt  = free_ok_r;
    free_idx_nxt = free_idx_r;
    best_ok_nxt  = best_ok_r;
    best_pos_nxt = best_pos_r;
    best_own_nxt = best_own_r;
    low_ok_nxt   = low_ok_r;
    low_pos_nxt  = low_pos_r;
    low_own_nxt  = low_own_r;
    if (scan_start) begin
      dup_nxt     = 1'b0;
      free_ok_nxt = 1'b0;
      best_ok_nxt = 1'b0;
      low_ok_nxt  = 1'b0;
    end else if (rd_vld_r) begin
      if (ent_valid && rd_pos_r == key_r) begin
        dup_nxt = 1'b1;
      end
      if (!ent_valid && !free_ok_r) begin
        free_ok_nxt  = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
      if (ent_valid && (!low_ok_r || rd_pos_r < low_pos_r)) begin
        low_ok_nxt  = 1'b1;
        low_pos_nxt = rd_pos_r;
        low_own_nxt = rd_own_r;
      end
      if (ent_valid && rd_pos_r > key_r && (!best_ok_r || rd_pos_r < best_pos_r)) begin
        best_ok_nxt  = 1'b1;
        best_pos_nxt = rd_pos_r;
        best_own_nxt = rd_own_r;
      end
    end
  end

  // Table memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ins_commit) begin
      pos_mem[free_idx_r] <= key_r;
      own_mem[free_idx_r] <= node_r;
    end
    rd_pos_r <= pos_mem[addr_r];
    rd_own_r <= own_mem[addr_r];
    rd_idx_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < NODES; i++) begin
        cnt_r[i] <= '0;
      end
      np_r <= '0;
    end else begin
      if (rem_clear) begin
        valid_r[rd_idx_r] <= 1'b0;
      end
      if (ins_commit) begin
        valid_r[free_idx_r] <= 1'b1;
        cnt_r[node_r]       <= cnt_r[node_r] + CW'(1);
        if (cnt_r[node_r] == '0) begin
          np_r <= np_r + NP_W'(1);
        end
      end
      if (rem_commit) begin
        cnt_r[node_r] <= '0;
        np_r          <= np_r - NP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cont_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == B_SCAN);
      cont_r   <= cont_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    node_r     <= node_nxt;
    want_r     <= want_nxt;
    n_r        <= n_nxt;
    seen_r     <= seen_nxt;
    dup_r      <= dup_nxt;
    free_ok_r  <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
    best_ok_r  <= best_ok_nxt;
    best_pos_r <= best_pos_nxt;
    best_own_r <= best_own_nxt;
    low_ok_r   <= low_ok_nxt;
    low_pos_r  <= low_pos_nxt;
    low_own_r  <= low_own_nxt;
    res_own_r  <= res_own_nxt;
    res_rank_r <= res_rank_nxt;
    res_stat_r <= res_stat_nxt;
    res_last_r <= res_last_nxt;
    if (load_out) begin
      out_own_r  <= res_own_r;
      out_rank_r <= res_rank_r;
      out_stat_r <= res_stat_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.owner_node   = out_own_r;
  assign out_ch.replica_rank = out_rank_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.last         = out_last_r;

  // The present-node count never exceeds the node space.
  a_np_bound: assert property (@(posedge clk) disable iff (!rst_n)
    np_r <= NP_W'(NODES))
    else $error("present node count out of range");

  // With no node present, no table entry may be valid.
  a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (np_r == '0) |-> (valid_r == '0))
    else $error("valid entry with no node present");

  // A lookup result always ranks below the number of owners wanted.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT && op_r == OP_LOOKUP && res_stat_r == ST_OK)
      |-> (NP_W'(res_rank_r) < want_r))
    else $error("replica rank beyond wanted count");

  // Taking a command always starts work on it.
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != B_IDLE))
    else $error("command taken but engine stayed idle");

endmodule

// ===== tb/consistent_hash_ring_placement_top_tb.sv =====
// Self-checking testbench for the consistent-hash ring placement block.
// Depends on chrp_pkg, the chrp_if channel interfaces and the top level RTL.
module consistent_hash_ring_placement_top_tb;
  import chrp_pkg::*;

  localparam int DEPTH       = 64;
  localparam int MAX_REPL    = 8;
  localparam int CYCLE_LIMIT = 4000000;
  // After the last expected word, a lookup walking the whole ring may still be busy.
  localparam int SETTLE      = 400;
  localparam int LONG_HOLD   = 600;
  // The fourth request type code is unused; the block drops such words.
  localparam logic [TYPE_W-1:0] REQ_IGNORED = 2'd3;

  typedef struct {
    logic [NODE_W-1:0] owner;
    logic [RANK_W-1:0] rank;
    logic [STAT_W-1:0] status;
    logic              last;
  } placement_t;

  logic clk;
  logic rst_n;

  chrp_req_if in_ch();
  chrp_res_if out_ch();
  chrp_cfg_if cfg_ch();

  consistent_hash_ring_placement_top #(
    .TABLE_DEPTH (DEPTH),
    .MAX_REPLICAS(MAX_REPL)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  // Shadow copy of the ring: positions, owners, occupancy and per-node entry counts.
  logic [POS_W-1:0]  ring_pos   [DEPTH];
  logic [NODE_W-1:0] ring_owner [DEPTH];
  bit                ring_used  [DEPTH];
  int unsigned       node_count [NODES];
  int unsigned       live_nodes;
  logic [RC_W-1:0]   replicas;

  placement_t pending_placements[$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned words_checked;
  int unsigned lookups_sent;
  int unsigned burst_left;
  int unsigned hold_request;

  // Index of the occupied entry with the smallest position strictly above the key,
  // wrapping to the smallest position overall; -1 when the ring is empty.
  function automatic int next_clockwise(logic [POS_W-1:0] key);
    int above;
    int lowest;
    above  = -1;
    lowest = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (ring_used[i]) begin
        if (lowest < 0 || ring_pos[i] < ring_pos[lowest]) lowest = i;
        if (ring_pos[i] > key && (above < 0 || ring_pos[i] < ring_pos[above])) above = i;
      end
    end
    return (above >= 0) ? above : lowest;
  endfunction

  function automatic void expect_word(logic [NODE_W-1:0] owner, logic [RANK_W-1:0] rank,
                                      logic [STAT_W-1:0] status, logic last);
    placement_t p;
    p.owner  = owner;
    p.rank   = rank;
    p.status = status;
    p.last   = last;
    pending_placements.insert(pending_placements.size(), p);
  endfunction

  // Applies one accepted request to the shadow ring and queues the words it yields.
  function automatic void place_request(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                                        logic [NODE_W-1:0] node);
    int free_slot;
    int cur;
    int found;
    int unsigned want;
    bit seen[NODES];
    bit dup;
    if (kind == REQ_INSERT) begin
      free_slot = -1;
      dup = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (ring_used[i] && ring_pos[i] == pos) dup = 1;
        if (!ring_used[i] && free_slot < 0) free_slot = i;
      end
      // A repeated position wins over a full table.
      if (dup) expect_word(node, 0, ST_DUP, 1'b1);
      else if (free_slot < 0) expect_word(node, 0, ST_FULL, 1'b1);
      else begin
        ring_used[free_slot]  = 1;
        ring_pos[free_slot]   = pos;
        ring_owner[free_slot] = node;
        if (node_count[node] == 0) live_nodes++;
        node_count[node]++;
        expect_word(node, 0, ST_OK, 1'b1);
      end
    end else if (kind == REQ_REMOVE) begin
      if (node_count[node] == 0) expect_word(node, 0, ST_NOTFOUND, 1'b1);
      else begin
        for (int i = 0; i < DEPTH; i++)
          if (ring_used[i] && ring_owner[i] == node) ring_used[i] = 0;
        node_count[node] = 0;
        live_nodes--;
        expect_word(node, 0, ST_OK, 1'b1);
      end
    end else if (kind == REQ_LOOKUP) begin
      cur = next_clockwise(pos);
      if (cur < 0) expect_word(0, 0, ST_EMPTY, 1'b1);
      else begin
        // Zero replicas means one, and the count saturates at the hardware maximum.
        want = (replicas == 0) ? 1 : replicas;
        if (want > MAX_REPL) want = MAX_REPL;
        if (want > live_nodes) want = live_nodes;
        found = 0;
        for (int s = 0; s < DEPTH && found < want; s++) begin
          if (!seen[ring_owner[cur]]) begin
            seen[ring_owner[cur]] = 1;
            expect_word(ring_owner[cur], found[RANK_W-1:0], ST_OK, found + 1 == want);
            found++;
          end
          cur = next_clockwise(ring_pos[cur]);
        end
      end
    end
  endfunction

  // Compares every accepted result word against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_placements.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word owner=%0d rank=%0d status=%0d last=%0d", $time,
                 out_ch.owner_node, out_ch.replica_rank, out_ch.status, out_ch.last);
      end else begin
        placement_t exp_w;
        exp_w = pending_placements.pop_front();
        if (out_ch.owner_node !== exp_w.owner || out_ch.replica_rank !== exp_w.rank ||
            out_ch.status !== exp_w.status || out_ch.last !== exp_w.last) begin
          mismatches++;
          $display("%0t: expected owner=%0d rank=%0d status=%0d last=%0d", $time,
                   exp_w.owner, exp_w.rank, exp_w.status, exp_w.last);
          $display("%0t:   actual owner=%0d rank=%0d status=%0d last=%0d", $time,
                   out_ch.owner_node, out_ch.replica_rank, out_ch.status, out_ch.last);
        end
      end
    end
  end

  // Receiver: random stalls, with long runs of steady readiness, and a long
  // hold-off whenever a test asks for one.
  always @(posedge clk) begin
    int unsigned hold_left;
    int unsigned phase;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (phase % 512 < 128) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words pending", cycle_count,
               pending_placements.size());
      $display("consistent_hash_ring_placement_top verification failed");
      $finish;
    end
  end

  // Sends one request word and records its effect once it is accepted.
  // The sender works in bursts; between most bursts valid drops for a random gap.
  // Ready is sampled mid-cycle, so the edge that follows accepts the word exactly
  // when the sampled value was high.
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [NODE_W-1:0] node);
    int unsigned gap;
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= kind;
    in_ch.ring_position <= pos;
    in_ch.node_number   <= node;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    if (kind == REQ_LOOKUP) lookups_sent++;
    place_request(kind, pos, node);
  endtask

  // Stops offering words and waits until every expected word has come back,
  // then lets any result-free work still inside the block finish.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the replica count; only called while the block is idle.
  task automatic write_replicas(logic [RC_W-1:0] value);
    bit taken;
    wait_drained();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.replica_count <= value;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
    cfg_ch.valid <= 1'b0;
    replicas = value;
  endtask

  task automatic clear_ring();
    for (int n = 0; n < NODES; n++)
      if (node_count[n] != 0) send_request(REQ_REMOVE, '0, n[NODE_W-1:0]);
  endtask

  // Empty ring: lookup, remove of an absent node, and an ignored request type.
  task automatic test_empty_ring();
    send_request(REQ_LOOKUP, '1, 4'd9);
    send_request(REQ_REMOVE, '0, 4'd15);
    send_request(REQ_IGNORED, '1, 4'd7);
    send_request(REQ_LOOKUP, '0, 4'd0);
  endtask

  // Field extremes, duplicates, wrap, exact-match keys and removal.
  task automatic test_basic_ring();
    send_request(REQ_INSERT, '0, 4'd0);
    send_request(REQ_INSERT, '1, 4'd15);
    send_request(REQ_INSERT, 64'h5555_5555_5555_5555, 4'd5);
    send_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd10);
    send_request(REQ_INSERT, 64'h8000_0000_0000_0000, 4'd5);
    send_request(REQ_INSERT, '1, 4'd3);
    send_request(REQ_LOOKUP, '1, 4'd0);
    send_request(REQ_LOOKUP, '0, 4'd0);
    send_request(REQ_LOOKUP, 64'h5555_5555_5555_5555, 4'd0);
    send_request(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0);
    send_request(REQ_REMOVE, '0, 4'd5);
    send_request(REQ_REMOVE, '0, 4'd5);
    send_request(REQ_IGNORED, 64'h1234, 4'd0);
    send_request(REQ_LOOKUP, 64'h6000_0000_0000_0000, 4'd0);
  endtask

  // Replica count extremes, including zero and values above the maximum.
  task automatic test_replica_settings();
    logic [RC_W-1:0] settings[6] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd2};
    for (int n = 0; n < 12; n++)
      send_request(REQ_INSERT, {$urandom, $urandom}, n[NODE_W-1:0]);
    foreach (settings[k]) begin
      write_replicas(settings[k]);
      send_request(REQ_LOOKUP, {$urandom, $urandom}, 4'd0);
      send_request(REQ_LOOKUP, '1, 4'd0);
    end
    write_replicas(4'd4);
  endtask

  // Fills all entries, tries one more and a duplicate while full, then looks up.
  task automatic test_full_table();
    clear_ring();
    for (int i = 0; i < DEPTH; i++)
      send_request(REQ_INSERT, {32'hC0DE_0000, i[31:0]}, i[NODE_W-1:0]);
    send_request(REQ_INSERT, 64'h0123_4567_89AB_CDEF, 4'd1);
    send_request(REQ_INSERT, {32'hC0DE_0000, 32'd7}, 4'd2);
    write_replicas(4'd8);
    send_request(REQ_LOOKUP, {32'hC0DE_0000, 32'd60}, 4'd0);
    send_request(REQ_LOOKUP, '0, 4'd0);
    clear_ring();
  endtask

  // Receiver holds off for a long stretch while lookups keep coming, so the
  // block backs up and stalls its input; then the sender waits for the drain.
  task automatic test_backpressure();
    for (int n = 0; n < 10; n++)
      send_request(REQ_INSERT, {$urandom, $urandom}, n[NODE_W-1:0]);
    wait_drained();
    hold_request = LONG_HOLD;
    burst_left = 40;
    for (int k = 0; k < 12; k++) send_request(REQ_LOOKUP, {$urandom, $urandom}, 4'd0);
    wait_drained();
  endtask

  // Random mix, mostly inserts and lookups; some keys on or just below an entry.
  task automatic test_random_traffic(int unsigned count);
    logic [POS_W-1:0] pos;
    logic [TYPE_W-1:0] kind;
    int unsigned pick;
    int unsigned used;
    int idx;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 3) write_replicas(RC_W'($urandom_range(0, 15)));
      if (k == 2 * count / 3) write_replicas(4'd8);
      used = 0;
      for (int i = 0; i < DEPTH; i++) used += ring_used[i];
      pick = $urandom_range(0, 99);
      if (pick < ((used > 48) ? 15 : 45)) kind = REQ_INSERT;
      else if (pick < 55) kind = REQ_REMOVE;
      else if (pick < 58) kind = REQ_IGNORED;
      else kind = REQ_LOOKUP;
      pos = {$urandom, $urandom};
      idx = $urandom_range(0, DEPTH - 1);
      case ($urandom_range(0, 7))
        0: pos = '0;
        1: pos = '1;
        2: if (ring_used[idx]) pos = ring_pos[idx];
        3: if (ring_used[idx]) pos = ring_pos[idx] - 1;
        default: ;
      endcase
      send_request(kind, pos, NODE_W'($urandom_range(0, NODES - 1)));
    end
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.req_type = REQ_INSERT;
    in_ch.ring_position = '0;
    in_ch.node_number = '0;
    cfg_ch.valid = 0;
    cfg_ch.replica_count = 4'(RESET_REPLICAS);
    out_ch.ready = 0;
    replicas = 4'(RESET_REPLICAS);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_basic_ring();
    test_replica_settings();
    test_backpressure();
    test_full_table();
    write_replicas(4'd3);
    test_random_traffic(50);
    wait_drained();

    $display("Covered %0d requests (%0d lookups) and %0d result words across empty,",
             items_sent, lookups_sent, words_checked);
    $display("full, duplicate, replica-limit, wrap and long-stall cases.");
    if (mismatches == 0 && pending_placements.size() == 0) begin
      $display("consistent_hash_ring_placement_top verification clean");
    end else begin
      $display("consistent_hash_ring_placement_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/chrp_pkg.sv
hw/rtl/chrp_if.sv
hw/rtl/chrp_front.sv
hw/rtl/chrp_back.sv
hw/rtl/consistent_hash_ring_placement_top.sv
tb/consistent_hash_ring_placement_top_tb.sv
